FILE: rtl/core/ggc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ggc_pkg;
    // input modes
    localparam logic [1:0] MODE_INSERT   = 2'd0;
    localparam logic [1:0] MODE_REMOVE   = 2'd1;
    localparam logic [1:0] MODE_COLOR    = 2'd2;
    localparam logic [1:0] MODE_COLOR_WP = 2'd3;
    // register addresses
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [5:0] VERTEX_COUNT_RESET = 6'd32;
endpackage
`default_nettype wire

FILE: rtl/core/greedy_graph_colorer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | direction | contents
// s_axis    | in        | tdata: mode[1:0], vertex_a[7:2], vertex_b[13:8]
// m_axis    | out       | tdata: vertex, color, color_count, bad_edge; tlast: last
// apb       | in/out    | vertex_count at address 0
// edits can follow back to back; a bad remove holds the input until its result
// is taken. a coloring run takes the request, counts degrees, sorts by degree
// (MODE_COLOR_WP only), runs the color pass and emits the output, all through
// one shared scan unit; the degree count and the color pass look at one matrix
// bit a cycle. no request is taken while a run is active or a result waits;
// output stalls hold the run. reset clears the matrix (flip-flops) and sets
// vertex_count to 32.
module greedy_graph_colorer_core
    import ggc_pkg::*;
#(
    parameter int MAX_VERTICES = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // mode, vertex_a, vertex_b, zero fill
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // vertex, color, color_count, bad_edge, zero fill
    output logic        m_axis_tlast,   // last
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DEG, S_SORT_CMP, S_COL_SCAN, S_COL_PICK, S_OUT_SCAN, S_OUT_WAIT
    } t_state;

    t_state r_state;
    logic [5:0]  r_vcount;
    logic [MAX_VERTICES-1:0] r_adj [MAX_VERTICES];
    logic [CW-1:0] r_deg [MAX_VERTICES];
    logic [CW-1:0] r_col [MAX_VERTICES];
    logic [VW-1:0] r_ord [MAX_VERTICES];
    logic [CW-1:0] r_i, r_j, r_n, r_c, r_top;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_pend_v;
    logic          r_pend;
    logic          r_wp;
    logic [MAX_VERTICES:0] r_taken;

    // effective vertex count
    logic [CW-1:0] w_n;
    always_comb begin
        if (32'(r_vcount) > 32'(MAX_VERTICES)) w_n = CW'(MAX_VERTICES);
        else w_n = CW'(r_vcount);
    end

    assign pready = 1'b1;
    assign prdata = ({1'b0, paddr[2]} == REG_VERTEX_COUNT) ? {26'd0, r_vcount} : 32'd0;
    assign s_axis_tready = (r_state == S_IDLE) && !m_axis_tvalid;

    logic [1:0] w_mode;
    logic [5:0] w_a, w_b;
    assign w_mode = s_axis_tdata[1:0];
    assign w_a = s_axis_tdata[7:2];
    assign w_b = s_axis_tdata[13:8];

    // shared scan unit signals
    logic [VW-1:0] w_iv, w_jv, w_ou;
    assign w_iv = r_i[VW-1:0];
    assign w_jv = r_j[VW-1:0];
    assign w_ou = r_ord[w_iv];
    logic w_before;
    assign w_before = (r_deg[r_ord[w_jv]] != r_deg[w_ou])
        ? (r_deg[r_ord[w_jv]] > r_deg[w_ou]) : (r_ord[w_jv] < w_ou);
    // running degree of the current row
    logic [CW-1:0] w_deg_sum;
    assign w_deg_sum = r_cnt + CW'(r_adj[w_iv][w_jv]);
    // lowest free color
    logic [CW-1:0] w_free;
    always_comb begin
        w_free = CW'(1);
        for (int k = MAX_VERTICES; k >= 1; k--)
            if (!r_taken[k] && k <= int'(r_n)) w_free = CW'(k);
        if (w_free == CW'(1) && r_taken[1]) w_free = r_n + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vcount <= VERTEX_COUNT_RESET;
            m_axis_tvalid <= 1'b0;
            for (int k = 0; k < MAX_VERTICES; k++) r_adj[k] <= '0;
        end else begin
            if (psel && penable && pwrite && {1'b0, paddr[2]} == REG_VERTEX_COUNT)
                r_vcount <= pwdata[5:0];
            unique case (r_state)
                S_IDLE: begin
                    if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_n <= w_n;
                        r_wp <= (w_mode == MODE_COLOR_WP);
                        unique case (w_mode)
                            MODE_INSERT: begin
                                if (CW'(w_a) < w_n && CW'(w_b) < w_n && w_a != w_b
                                    && {1'b0, w_a} < 7'(MAX_VERTICES)
                                    && {1'b0, w_b} < 7'(MAX_VERTICES)) begin
                                    r_adj[w_a[VW-1:0]][w_b[VW-1:0]] <= 1'b1;
                                    r_adj[w_b[VW-1:0]][w_a[VW-1:0]] <= 1'b1;
                                end
                            end
                            MODE_REMOVE: begin
                                if ({1'b0, w_a} >= 7'(w_n) || {1'b0, w_b} >= 7'(w_n)) begin
                                    m_axis_tvalid <= 1'b1;
                                    m_axis_tdata <= 24'h020000;
                                    m_axis_tlast <= 1'b1;
                                end else begin
                                    r_adj[w_a[VW-1:0]][w_b[VW-1:0]] <= 1'b0;
                                    r_adj[w_b[VW-1:0]][w_a[VW-1:0]] <= 1'b0;
                                end
                            end
                            default: begin
                                if (w_n != '0) begin
                                    r_i <= '0; r_j <= '0; r_cnt <= '0;
                                    r_state <= S_DEG;
                                end
                            end
                        endcase
                    end
                end
                // degree count, one matrix bit a cycle
                S_DEG: begin
                    if (r_j == r_n - CW'(1)) begin
                        r_deg[w_iv] <= w_deg_sum;
                        r_col[w_iv] <= '0;
                        r_ord[w_iv] <= w_iv;
                        r_j <= '0;
                        r_cnt <= '0;
                        if (r_i == r_n - CW'(1)) begin
                            if (r_wp && r_n > CW'(1)) begin
                                r_i <= CW'(1); r_state <= S_SORT_CMP;
                            end else begin
                                r_i <= '0; r_taken <= '0; r_top <= '0;
                                r_state <= S_COL_SCAN;
                            end
                        end else r_i <= r_i + CW'(1);
                    end else begin
                        r_cnt <= w_deg_sum;
                        r_j <= r_j + CW'(1);
                    end
                end
                // insertion sort: move vertex i left while it goes before its left neighbor
                S_SORT_CMP: begin
                    if (!w_before) begin
                        r_ord[w_jv] <= w_ou;
                        r_ord[w_iv] <= r_ord[w_jv];
                    end
                    if (!w_before && r_j != '0) begin
                        r_i <= r_j;
                        r_j <= r_j - CW'(1);
                    end else if (r_cnt + CW'(2) >= r_n) begin
                        r_i <= '0; r_j <= '0; r_taken <= '0; r_top <= '0;
                        r_state <= S_COL_SCAN;
                    end else begin
                        r_i <= r_cnt + CW'(2); r_j <= r_cnt + CW'(1);
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                // gather colors of neighbors of the current vertex
                S_COL_SCAN: begin
                    if (r_adj[w_ou][w_jv] && r_col[w_jv] != '0)
                        r_taken[r_col[w_jv]] <= 1'b1;
                    if (r_j == r_n - CW'(1)) begin
                        r_j <= '0; r_state <= S_COL_PICK;
                    end else r_j <= r_j + CW'(1);
                end
                S_COL_PICK: begin
                    r_col[w_ou] <= w_free;
                    if (w_free > r_top) r_top <= w_free;
                    r_taken <= '0;
                    if (r_i == r_n - CW'(1)) begin
                        r_c <= CW'(1); r_j <= '0; r_pend <= 1'b0;
                        r_state <= S_OUT_SCAN;
                    end else begin
                        r_i <= r_i + CW'(1); r_state <= S_COL_SCAN;
                    end
                end
                // emit in color order, one result held back to mark the last
                S_OUT_SCAN: begin
                    if (!m_axis_tvalid || m_axis_tready) begin
                        if (r_col[w_jv] == r_c && r_pend) begin
                            m_axis_tvalid <= 1'b1;
                            m_axis_tdata <= {6'd0, 1'b0, 6'(r_top), 6'(r_col[r_pend_v]),
                                5'(r_pend_v)};
                            m_axis_tlast <= 1'b0;
                        end else begin
                            m_axis_tvalid <= 1'b0;
                        end
                        if (r_col[w_jv] == r_c) begin
                            r_pend <= 1'b1; r_pend_v <= w_jv;
                        end
                        if (r_j == r_n - CW'(1)) begin
                            r_j <= '0;
                            if (r_c == r_top) r_state <= S_OUT_WAIT;
                            else r_c <= r_c + CW'(1);
                        end else r_j <= r_j + CW'(1);
                    end
                end
                default: begin
                    if (!m_axis_tvalid || m_axis_tready) begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tdata <= {6'd0, 1'b0, 6'(r_top), 6'(r_col[r_pend_v]),
                            5'(r_pend_v)};
                        m_axis_tlast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: verif/ggc_checker.sv
`timescale 1ns / 1ps
module ggc_checker
    import ggc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire  [15:0] s_axis_tdata,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [23:0] m_axis_tdata,
    input  wire         m_axis_tlast,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic       last;
        logic       bad_edge;
        logic [5:0] color_count;
        logic [5:0] color;
        logic [4:0] vertex;
    } t_color_result;

    logic [31:0]   adj [32];
    logic [5:0]    vcount;
    t_color_result expected_colors [$];

    assign o_pending = expected_colors.size();

    function automatic int active_vertices();
        return (vcount > 6'd32) ? 32 : int'(vcount);
    endfunction

    // append one expected result
    function automatic void add_expected(input t_color_result r);
        expected_colors.insert(expected_colors.size(), r);
    endfunction

    // greedy coloring, optionally visiting by descending degree
    task automatic predict_coloring(input bit by_degree);
        int n, top, c, u, v, j;
        int deg [32];
        int col [32];
        int order [32];
        bit taken [34];
        t_color_result r;
        n = active_vertices();
        top = 0;
        for (int i = 0; i < n; i++) begin
            deg[i] = 0;
            for (j = 0; j < n; j++) deg[i] += adj[i][j];
            col[i] = 0;
            order[i] = i;
        end
        if (by_degree) begin
            for (int i = 1; i < n; i++) begin
                v = order[i];
                j = i;
                while (j > 0 && (deg[v] > deg[order[j-1]] ||
                       (deg[v] == deg[order[j-1]] && v < order[j-1]))) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = v;
            end
        end
        for (int i = 0; i < n; i++) begin
            foreach (taken[k]) taken[k] = 0;
            u = order[i];
            for (j = 0; j < n; j++)
                if (adj[u][j] && col[j] != 0) taken[col[j]] = 1;
            c = 1;
            while (c <= n && taken[c]) c++;
            col[u] = c;
            if (c > top) top = c;
        end
        for (c = 1; c <= top; c++)
            for (u = 0; u < n; u++)
                if (col[u] == c) begin
                    r = '0;
                    r.vertex = u[4:0];
                    r.color = c[5:0];
                    r.color_count = top[5:0];
                    add_expected(r);
                end
        if (n > 0) begin
            expected_colors[expected_colors.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        logic [1:0] mode;
        int a, b, n;
        t_color_result r, got;
        if (!i_rst_n) begin
            foreach (adj[i]) adj[i] <= '0;
            vcount <= VERTEX_COUNT_RESET;
            o_fail_count <= 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && {1'b0, paddr[2]} == REG_VERTEX_COUNT)
                vcount <= pwdata[5:0];
            // accepted requests
            if (s_axis_tvalid && s_axis_tready) begin
                mode = s_axis_tdata[1:0];
                a = s_axis_tdata[7:2];
                b = s_axis_tdata[13:8];
                n = active_vertices();
                case (mode)
                    MODE_INSERT: begin
                        if (a < n && b < n && a != b) begin
                            adj[a][b] = 1'b1;
                            adj[b][a] = 1'b1;
                        end
                    end
                    MODE_REMOVE: begin
                        if (a >= n || b >= n) begin
                            r = '0;
                            r.bad_edge = 1'b1;
                            r.last = 1'b1;
                            add_expected(r);
                        end else begin
                            adj[a][b] = 1'b0;
                            adj[b][a] = 1'b0;
                        end
                    end
                    MODE_COLOR:    predict_coloring(1'b0);
                    MODE_COLOR_WP: predict_coloring(1'b1);
                    default: ;
                endcase
            end
            // compare results
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tlast, m_axis_tdata[17:0]};
                if (expected_colors.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    r = expected_colors.pop_front();
                    if (got !== r) begin
                        $display("%0t: mismatch expected v=%0d c=%0d cc=%0d bad=%0d last=%0d",
                                 $time, r.vertex, r.color, r.color_count, r.bad_edge, r.last);
                        $display("%0t:          actual   v=%0d c=%0d cc=%0d bad=%0d last=%0d",
                                 $time, got.vertex, got.color, got.color_count,
                                 got.bad_edge, got.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/tb_greedy_graph_colorer_core.sv
`timescale 1ns / 1ps
module tb_greedy_graph_colorer_core;
    import ggc_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // mode, vertex_a, vertex_b, zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;         // vertex, color, color_count, bad_edge, zero fill
    logic        m_axis_tlast;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending;
    int          cycle = 0;
    bit          calm = 0;
    bit          hold_off = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    greedy_graph_colorer_core u_dut (.*);

    ggc_checker u_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // run limit
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > 20000000) begin
            $display("tb_greedy_graph_colorer_core: FAIL");
            $finish;
        end
    end

    // receiver with random stall bursts and one long hold-off
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 0;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 16);
                m_axis_tready <= 0;
                repeat (gap - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    task automatic send_request(input logic [1:0] mode, input logic [5:0] a,
                                input logic [5:0] b);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {2'b00, b, a, mode};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [5:0] value);
        drain();
        psel <= 1; pwrite <= 1; paddr <= {REG_VERTEX_COUNT[0], 2'b00};
        pwdata <= {26'h0, value};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // mostly in-range edits with occasional out-of-range endpoints
    function automatic logic [5:0] pick_vertex(input int n);
        if (n == 0 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, n - 1));
    endfunction

    task automatic random_phase(input int n, input int items);
        int r;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55)      send_request(MODE_INSERT, pick_vertex(n), pick_vertex(n));
            else if (r < 80) send_request(MODE_REMOVE, pick_vertex(n), pick_vertex(n));
            else if (r < 90) send_request(MODE_COLOR, 6'($urandom), 6'($urandom));
            else             send_request(MODE_COLOR_WP, 6'($urandom), 6'($urandom));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: empty graph, extremes, self-loop, bad removes
        send_request(MODE_COLOR, 6'd0, 6'd0);
        send_request(MODE_INSERT, 6'd0, 6'd31);
        send_request(MODE_INSERT, 6'd5, 6'd5);
        send_request(MODE_INSERT, 6'd63, 6'd1);
        send_request(MODE_INSERT, 6'd0, 6'd1);
        send_request(MODE_INSERT, 6'd1, 6'd31);
        send_request(MODE_INSERT, 6'd2, 6'd3);
        send_request(MODE_COLOR_WP, 6'd63, 6'd63);
        send_request(MODE_REMOVE, 6'd32, 6'd0);
        send_request(MODE_REMOVE, 6'd0, 6'd63);
        send_request(MODE_REMOVE, 6'd4, 6'd7);
        send_request(MODE_REMOVE, 6'd0, 6'd31);
        send_request(MODE_COLOR, 6'd42, 6'd21);
        // full-size random graph, with the long receiver hold-off
        hold_off = 1;
        random_phase(32, 60);
        // shrink: stored edges above n are kept
        write_vertex_count(6'd8);
        random_phase(8, 90);
        write_vertex_count(6'd0);
        send_request(MODE_COLOR, 6'd0, 6'd0);
        send_request(MODE_REMOVE, 6'd0, 6'd0);
        send_request(MODE_INSERT, 6'd0, 6'd1);
        write_vertex_count(6'd63);
        random_phase(32, 50);
        write_vertex_count(6'd1);
        random_phase(1, 20);
        write_vertex_count(6'd5);
        random_phase(5, 120);
        write_vertex_count(6'd32);
        calm = 1;
        random_phase(32, 100);
        drain();
        if (fail_count == 0) begin
            $display("tb_greedy_graph_colorer_core: PASS");
        end else begin
            $display("tb_greedy_graph_colorer_core: FAIL");
        end
        $finish;
    end
endmodule
